// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the core top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Antecedent implies consequent in the next cycle
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/iopit_pkg.sv =====
// Types, codes and helper functions for the I/O port and interval timer core
package iopit_pkg;

  // Item operation codes
  typedef enum logic [2:0] {
    OP_READ    = 3'd0,
    OP_WRITE   = 3'd1,
    OP_TICK    = 3'd2,
    OP_PINS_A  = 3'd3,
    OP_PINS_B  = 3'd4
  } op_e;

  // Timer phase
  typedef enum logic [0:0] {
    PHASE_COUNTING  = 1'b0,
    PHASE_FINISHING = 1'b1
  } phase_e;

  localparam int unsigned TicksW = 19;

  // Interrupt flag and enable bit positions
  localparam int unsigned FLAG_TIMER = 1;
  localparam int unsigned FLAG_PA7   = 0;

  localparam logic [TicksW-1:0] PERIOD_TICKS = 19'd256;
  localparam logic [TicksW-1:0] TICKS_RESET  = 19'd262144;
  localparam logic [1:0]        SHIFT_SEL_RESET = 2'd3;
  localparam logic [7:0]        TIMER_LAST = 8'hff;

  typedef struct packed {
    logic [2:0] opcode;
    logic [4:0] address;
    logic [7:0] data;
    logic [7:0] mask;
    logic       quiet;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq;
    logic [7:0] port_a_out;
    logic [7:0] port_b_out;
    logic [7:0] port_a_dir;
    logic [7:0] port_b_dir;
  } out_item_t;

  // Interrupt status seen by the top level
  typedef struct packed {
    logic [1:0] flags;
    logic [1:0] enables;
  } irq_status_t;

  // Value seen on a port: driven bits from the output register, others from pins
  function automatic logic [7:0] port_value(logic [7:0] pins, logic [7:0] outr,
                                            logic [7:0] dir);
    return (outr & dir) | (pins & ~dir);
  endfunction

  // Prescaled count shifted down by the selected prescale
  function automatic logic [TicksW-1:0] prescale_down(logic [TicksW-1:0] t,
                                                      logic [1:0] sel);
    logic [TicksW-1:0] r;
    unique case (sel)
      2'd0:    r = t;
      2'd1:    r = t >> 3;
      2'd2:    r = t >> 6;
      default: r = t >> 10;
    endcase
    return r;
  endfunction

  // Timer value as read on the bus
  function automatic logic [7:0] timer_value(phase_e ph, logic [TicksW-1:0] t,
                                             logic [1:0] sel);
    logic [TicksW-1:0] s;
    s = prescale_down(t, sel);
    return (ph == PHASE_COUNTING) ? s[7:0] : t[7:0];
  endfunction

  // Count loaded on a timer write: one plus data scaled by the prescale
  function automatic logic [TicksW-1:0] timer_load(logic [7:0] data, logic [1:0] sel);
    logic [TicksW-1:0] d;
    logic [TicksW-1:0] s;
    d = TicksW'(data);
    unique case (sel)
      2'd0:    s = d;
      2'd1:    s = d << 3;
      2'd2:    s = d << 6;
      default: s = d << 10;
    endcase
    return s + TicksW'(1);
  endfunction

endpackage

// ===== rtl/core/iopit_exec.sv =====
// Register file and combinational execute logic for one item
module iopit_exec (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   commit_i,
  input  iopit_pkg::in_item_t    item_i,
  output iopit_pkg::out_item_t   result_o,
  output iopit_pkg::irq_status_t status_o
);

  logic [7:0] pins_a_q, pins_a_d, pins_b_q, pins_b_d;
  logic [7:0] out_a_q, out_a_d, out_b_q, out_b_d;
  logic [7:0] dir_a_q, dir_a_d, dir_b_q, dir_b_d;
  logic [1:0] flags_q, flags_d, en_q, en_d;
  logic       edge_rise_q, edge_rise_d;
  logic       prev7_q, prev7_d;
  logic [1:0] shsel_q, shsel_d;
  iopit_pkg::phase_e phase_q, phase_d;
  logic [iopit_pkg::TicksW-1:0] ticks_q, ticks_d, ticks_dec;

  logic [7:0] mrg_a, mrg_b, tval, tval_w, port_a_new, rd;
  logic       edge_chk;

  // Merge pin samples under the mask
  assign mrg_a = (pins_a_q & ~item_i.mask) | (item_i.data & item_i.mask);
  assign mrg_b = (pins_b_q & ~item_i.mask) | (item_i.data & item_i.mask);
  assign tval   = iopit_pkg::timer_value(phase_q, ticks_q, shsel_q);
  assign tval_w = iopit_pkg::timer_value(phase_q, ticks_q, item_i.address[1:0]);
  assign ticks_dec = ticks_q - iopit_pkg::TicksW'(ticks_q != '0);

  // Decode the item and form the next state
  always_comb begin
    pins_a_d    = pins_a_q;
    pins_b_d    = pins_b_q;
    out_a_d     = out_a_q;
    out_b_d     = out_b_q;
    dir_a_d     = dir_a_q;
    dir_b_d     = dir_b_q;
    flags_d     = flags_q;
    en_d        = en_q;
    edge_rise_d = edge_rise_q;
    prev7_d     = prev7_q;
    shsel_d     = shsel_q;
    phase_d     = phase_q;
    ticks_d     = ticks_q;
    rd          = '0;
    edge_chk    = 1'b0;
    unique case (item_i.opcode)
      iopit_pkg::OP_READ: begin
        if (item_i.address[2] && item_i.address[0]) begin
          rd = {flags_q, 6'b0};
          if (!item_i.quiet) flags_d[iopit_pkg::FLAG_PA7] = 1'b0;
        end else if (item_i.address[2]) begin
          rd = tval;
          if (!item_i.quiet) begin
            en_d[iopit_pkg::FLAG_TIMER] = item_i.address[3];
            if (phase_q != iopit_pkg::PHASE_FINISHING || tval != iopit_pkg::TIMER_LAST) begin
              flags_d[iopit_pkg::FLAG_TIMER] = 1'b0;
            end
          end
        end else if (item_i.address[1]) begin
          if (item_i.address[0]) begin
            rd = dir_b_q;
          end else begin
            pins_b_d = mrg_b;
            rd = iopit_pkg::port_value(mrg_b, out_b_q, dir_b_q);
          end
        end else begin
          if (item_i.address[0]) begin
            rd = dir_a_q;
          end else begin
            pins_a_d = mrg_a;
            edge_chk = (item_i.mask != '0) && !item_i.quiet;
            rd = iopit_pkg::port_value(mrg_a, out_a_q, dir_a_q);
          end
        end
      end
      iopit_pkg::OP_WRITE: begin
        if (item_i.address[4] && item_i.address[2]) begin
          shsel_d = item_i.address[1:0];
          en_d[iopit_pkg::FLAG_TIMER] = item_i.address[3];
          if (phase_q != iopit_pkg::PHASE_FINISHING || tval_w != iopit_pkg::TIMER_LAST) begin
            flags_d[iopit_pkg::FLAG_TIMER] = 1'b0;
          end
          phase_d = iopit_pkg::PHASE_COUNTING;
          ticks_d = iopit_pkg::timer_load(item_i.data, item_i.address[1:0]);
        end else if (item_i.address[2]) begin
          en_d[iopit_pkg::FLAG_PA7] = item_i.address[1];
          edge_rise_d = item_i.address[0];
        end else if (item_i.address[1]) begin
          if (item_i.address[0]) dir_b_d = item_i.data;
          else                   out_b_d = item_i.data;
        end else begin
          if (item_i.address[0]) dir_a_d = item_i.data;
          else                   out_a_d = item_i.data;
          edge_chk = 1'b1;
        end
      end
      iopit_pkg::OP_TICK: begin
        if (ticks_dec == '0) begin
          if (phase_q == iopit_pkg::PHASE_COUNTING) begin
            phase_d = iopit_pkg::PHASE_FINISHING;
            flags_d[iopit_pkg::FLAG_TIMER] = 1'b1;
          end
          ticks_d = iopit_pkg::PERIOD_TICKS;
        end else begin
          ticks_d = ticks_dec;
        end
      end
      iopit_pkg::OP_PINS_A: begin
        pins_a_d = mrg_a;
        edge_chk = 1'b1;
      end
      iopit_pkg::OP_PINS_B: begin
        pins_b_d = mrg_b;
      end
      default: begin
      end
    endcase

    // Evaluate the edge detector on the top bit of the updated port A
    port_a_new = iopit_pkg::port_value(pins_a_d, out_a_d, dir_a_d);
    if (edge_chk) begin
      if (port_a_new[7] != prev7_q && port_a_new[7] == edge_rise_q) begin
        flags_d[iopit_pkg::FLAG_PA7] = 1'b1;
      end
      prev7_d = port_a_new[7];
    end
  end

  // Result of this item, built from the updated state
  always_comb begin
    result_o.read_data  = rd;
    result_o.irq        = |(flags_d & en_d);
    result_o.port_a_out = out_a_d;
    result_o.port_b_out = out_b_d;
    result_o.port_a_dir = dir_a_d;
    result_o.port_b_dir = dir_b_d;
  end

  assign status_o.flags   = flags_q;
  assign status_o.enables = en_q;

  // Commit the state when the item leaves the execute stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pins_a_q    <= '0;
      pins_b_q    <= '0;
      out_a_q     <= '0;
      out_b_q     <= '0;
      dir_a_q     <= '0;
      dir_b_q     <= '0;
      flags_q     <= '0;
      en_q        <= '0;
      edge_rise_q <= 1'b0;
      prev7_q     <= 1'b0;
      shsel_q     <= iopit_pkg::SHIFT_SEL_RESET;
      phase_q     <= iopit_pkg::PHASE_COUNTING;
      ticks_q     <= iopit_pkg::TICKS_RESET;
    end else if (commit_i) begin
      pins_a_q    <= pins_a_d;
      pins_b_q    <= pins_b_d;
      out_a_q     <= out_a_d;
      out_b_q     <= out_b_d;
      dir_a_q     <= dir_a_d;
      dir_b_q     <= dir_b_d;
      flags_q     <= flags_d;
      en_q        <= en_d;
      edge_rise_q <= edge_rise_d;
      prev7_q     <= prev7_d;
      shsel_q     <= shsel_d;
      phase_q     <= phase_d;
      ticks_q     <= ticks_d;
    end
  end

endmodule

// ===== rtl/core/io_port_interval_timer_peripheral_core.sv =====
// Path: an item is held in the input reg, then its result in the result reg.
// Throughput: one item per cycle unless the output stalls; execute updates all state.
// A result waiting at the output stalls execute; one more item waits in the input reg.
// Reset: asynchronous, active low; ports, directions, flags and enables clear,
// prescale selects a shift of 10 and the timer counts from 262144.
// Top level of the I/O port and interval timer core
`include "assert_macros.svh"

module io_port_interval_timer_peripheral_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  iopit_pkg::in_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output iopit_pkg::out_item_t out_item_o
);

  logic                  s1_valid_q, s1_valid_d;
  iopit_pkg::in_item_t   s1_item_q;
  logic                  out_valid_q, out_valid_d;
  iopit_pkg::out_item_t  out_item_q, exec_result;
  iopit_pkg::irq_status_t exec_status;
  logic                  in_xfer, s1_fire;

  // Advance the execute stage when the result register is free or drains
  assign s1_fire    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_fire;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_xfer)      s1_valid_d = 1'b1;
    else if (s1_fire) s1_valid_d = 1'b0;
    out_valid_d = out_valid_q;
    if (s1_fire)                         out_valid_d = 1'b1;
    else if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
  end

  // Hold valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture payloads
  always_ff @(posedge clk_i) begin
    if (in_xfer) s1_item_q  <= in_item_i;
    if (s1_fire) out_item_q <= exec_result;
  end

  iopit_exec u_exec (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .commit_i (s1_fire),
    .item_i   (s1_item_q),
    .result_o (exec_result),
    .status_o (exec_status)
  );

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  `ASSERT_IMP(a_stall_cause, clk_i, rst_ni, !in_ready_o, s1_valid_q && out_valid_q && !out_ready_i)
  `ASSERT_NXT(a_fire_result, clk_i, rst_ni, s1_fire, out_valid_o)
  `ASSERT_IMP(a_irq_match, clk_i, rst_ni, out_valid_o, out_item_o.irq == |(exec_status.flags & exec_status.enables))

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the I/O port and interval timer core
module tb;

  localparam int unsigned STALL_LIMIT = 4000;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  iopit_pkg::in_item_t  in_item = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  iopit_pkg::out_item_t out_item;

  // Bus items waiting to be offered, and the outputs they should produce
  iopit_pkg::in_item_t  bus_items[$];
  iopit_pkg::out_item_t predicted_outputs[$];

  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned items_sent = 0;
  int unsigned total_items = 0;
  int unsigned idle_left = 0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned pick;
  bit          long_hold_done = 1'b0;

  // Predicted peripheral state
  logic [7:0]                   pa_pins, pb_pins, pa_out, pb_out, pa_dir, pb_dir;
  logic [1:0]                   irq_flags, irq_enables;
  logic                         edge_rise, pa7_last;
  logic [3:0]                   pit_shift;
  iopit_pkg::phase_e            pit_phase;
  logic [iopit_pkg::TicksW-1:0] pit_ticks;

  io_port_interval_timer_peripheral_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item)
  );

  always #4 clk_i = ~clk_i;

  // Level seen on a port: driven bits from the output register, the rest from pins
  function automatic logic [7:0] seen_level(logic [7:0] pins, logic [7:0] drv,
                                            logic [7:0] dir);
    return (drv & dir) | (pins & ~dir);
  endfunction

  // Re-sample PA7 and latch the edge flag on a change toward the selected level
  function automatic void sample_pa7();
    logic [7:0] lvl;
    lvl = seen_level(pa_pins, pa_out, pa_dir);
    if (lvl[7] != pa7_last && lvl[7] == edge_rise) irq_flags[iopit_pkg::FLAG_PA7] = 1'b1;
    pa7_last = lvl[7];
  endfunction

  function automatic logic [7:0] timer_now();
    logic [iopit_pkg::TicksW-1:0] scaled;
    scaled = pit_ticks >> pit_shift;
    return (pit_phase == iopit_pkg::PHASE_COUNTING) ? scaled[7:0] : pit_ticks[7:0];
  endfunction

  // Clear the timer flag unless the count sits at its last value after expiry
  function automatic void touch_timer_flag(logic [7:0] val);
    if (pit_phase != iopit_pkg::PHASE_FINISHING || val != iopit_pkg::TIMER_LAST)
      irq_flags[iopit_pkg::FLAG_TIMER] = 1'b0;
  endfunction

  // Apply one bus item to the predicted state and return the expected outputs
  function automatic iopit_pkg::out_item_t apply_bus_item(iopit_pkg::in_item_t it);
    iopit_pkg::out_item_t res;
    logic [4:0] a;
    logic [7:0] rd;
    a  = it.address;
    rd = 8'h00;
    case (it.opcode)
      iopit_pkg::OP_READ: begin
        if (a[2] && a[0]) begin
          rd = {irq_flags, 6'b0};
          if (!it.quiet) irq_flags[iopit_pkg::FLAG_PA7] = 1'b0;
        end else if (a[2]) begin
          rd = timer_now();
          if (!it.quiet) begin
            irq_enables[iopit_pkg::FLAG_TIMER] = a[3];
            touch_timer_flag(rd);
          end
        end else if (a[1]) begin
          if (a[0]) begin
            rd = pb_dir;
          end else begin
            if (it.mask != 8'h00) pb_pins = (pb_pins & ~it.mask) | (it.data & it.mask);
            rd = seen_level(pb_pins, pb_out, pb_dir);
          end
        end else begin
          if (a[0]) begin
            rd = pa_dir;
          end else begin
            if (it.mask != 8'h00) begin
              pa_pins = (pa_pins & ~it.mask) | (it.data & it.mask);
              if (!it.quiet) sample_pa7();
            end
            rd = seen_level(pa_pins, pa_out, pa_dir);
          end
        end
      end
      iopit_pkg::OP_WRITE: begin
        if (a[4] && a[2]) begin
          case (a[1:0])
            2'd0:    pit_shift = 4'd0;
            2'd1:    pit_shift = 4'd3;
            2'd2:    pit_shift = 4'd6;
            default: pit_shift = 4'd10;
          endcase
          irq_enables[iopit_pkg::FLAG_TIMER] = a[3];
          touch_timer_flag(timer_now());
          pit_phase = iopit_pkg::PHASE_COUNTING;
          pit_ticks = (iopit_pkg::TicksW'(it.data) << pit_shift) + iopit_pkg::TicksW'(1);
        end else if (a[2]) begin
          irq_enables[iopit_pkg::FLAG_PA7] = a[1];
          edge_rise = a[0];
        end else if (a[1]) begin
          if (a[0]) pb_dir = it.data;
          else pb_out = it.data;
        end else begin
          if (a[0]) pa_dir = it.data;
          else pa_out = it.data;
          sample_pa7();
        end
      end
      iopit_pkg::OP_TICK: begin
        if (pit_ticks != '0) pit_ticks = pit_ticks - iopit_pkg::TicksW'(1);
        if (pit_ticks == '0) begin
          if (pit_phase == iopit_pkg::PHASE_COUNTING) begin
            pit_phase = iopit_pkg::PHASE_FINISHING;
            irq_flags[iopit_pkg::FLAG_TIMER] = 1'b1;
          end
          pit_ticks = iopit_pkg::PERIOD_TICKS;
        end
      end
      iopit_pkg::OP_PINS_A: begin
        pa_pins = (pa_pins & ~it.mask) | (it.data & it.mask);
        sample_pa7();
      end
      iopit_pkg::OP_PINS_B: begin
        pb_pins = (pb_pins & ~it.mask) | (it.data & it.mask);
      end
      default: ;
    endcase
    res.read_data  = rd;
    res.irq        = |(irq_flags & irq_enables);
    res.port_a_out = pa_out;
    res.port_b_out = pb_out;
    res.port_a_dir = pa_dir;
    res.port_b_dir = pb_dir;
    return res;
  endfunction

  task automatic add_item(logic [2:0] op, logic [4:0] addr, logic [7:0] data,
                          logic [7:0] mask, logic quiet);
    iopit_pkg::in_item_t it;
    it.opcode  = op;
    it.address = addr;
    it.data    = data;
    it.mask    = mask;
    it.quiet   = quiet;
    bus_items.push_back(it);
  endtask

  // Program a short count, tick it until it expires, then read the timer and the flags
  task automatic queue_timer_run();
    int unsigned count;
    int unsigned extra;
    count = $urandom_range(0, 14);
    extra = $urandom_range(0, 2);
    add_item(iopit_pkg::OP_WRITE, {1'b1, 1'($urandom), 1'b1, 2'b00}, 8'(count),
             8'($urandom), 1'b0);
    repeat (count + 1 + extra) add_item(iopit_pkg::OP_TICK, 5'($urandom), 8'($urandom),
                                        8'($urandom), 1'($urandom));
    add_item(iopit_pkg::OP_READ, {1'($urandom), 1'($urandom), 1'b1, 1'($urandom), 1'b0},
             8'($urandom), 8'($urandom), ($urandom_range(0, 3) == 0));
    add_item(iopit_pkg::OP_READ, {2'($urandom), 1'b1, 1'($urandom), 1'b1},
             8'($urandom), 8'($urandom), ($urandom_range(0, 3) == 0));
  endtask

  task automatic queue_random_item();
    int unsigned r;
    logic [2:0]  op;
    r = $urandom_range(0, 99);
    if (r < 35)      op = iopit_pkg::OP_TICK;
    else if (r < 60) op = iopit_pkg::OP_READ;
    else if (r < 80) op = iopit_pkg::OP_WRITE;
    else if (r < 88) op = iopit_pkg::OP_PINS_A;
    else if (r < 95) op = iopit_pkg::OP_PINS_B;
    else             op = 3'($urandom_range(5, 7));
    add_item(op, 5'($urandom), 8'($urandom),
             ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom),
             ($urandom_range(0, 3) == 0));
  endtask

  task report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Offer queued items with random gaps and predict each transfer
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predicted_outputs.push_back(apply_bus_item(in_item));
        items_sent++;
      end
      if (!in_valid || in_ready) begin
        if (idle_left > 0) begin
          idle_left--;
          in_valid <= 1'b0;
        end else if (bus_items.size() != 0) begin
          in_item  <= bus_items.pop_front();
          in_valid <= 1'b1;
          pick = $urandom_range(0, 99);
          if ((items_sent / 90) % 3 == 1) idle_left = 0;
          else if (pick < 70) idle_left = 0;
          else if (pick < 95) idle_left = $urandom_range(1, 3);
          else idle_left = $urandom_range(10, 30);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver readiness: short random stalls, one long hold-off to back the core up
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!long_hold_done && results_seen >= 150) begin
      long_hold_done = 1'b1;
      hold_left = 120;
      out_ready <= 1'b0;
    end else if ((results_seen / 100) % 3 == 1) begin
      out_ready <= 1'b1;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        hold_left = (pick < 97) ? $urandom_range(0, 2) : $urandom_range(8, 25);
      end
    end
  end

  // Compare each result transfer with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      results_seen++;
      if (predicted_outputs.size() == 0) begin
        report_mismatch("result with no prediction pending");
      end else begin
        iopit_pkg::out_item_t exp;
        exp = predicted_outputs.pop_front();
        if (out_item.read_data !== exp.read_data)
          report_mismatch($sformatf("read_data %h, want %h", out_item.read_data, exp.read_data));
        if (out_item.irq !== exp.irq)
          report_mismatch($sformatf("irq %b, want %b", out_item.irq, exp.irq));
        if (out_item.port_a_out !== exp.port_a_out)
          report_mismatch($sformatf("port_a_out %h, want %h", out_item.port_a_out,
                                    exp.port_a_out));
        if (out_item.port_b_out !== exp.port_b_out)
          report_mismatch($sformatf("port_b_out %h, want %h", out_item.port_b_out,
                                    exp.port_b_out));
        if (out_item.port_a_dir !== exp.port_a_dir)
          report_mismatch($sformatf("port_a_dir %h, want %h", out_item.port_a_dir,
                                    exp.port_a_dir));
        if (out_item.port_b_dir !== exp.port_b_dir)
          report_mismatch($sformatf("port_b_dir %h, want %h", out_item.port_b_dir,
                                    exp.port_b_dir));
      end
    end
  end

  // Abort when neither side has moved a transfer for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    // Reset state of the prediction
    pa_pins = '0; pb_pins = '0; pa_out = '0; pb_out = '0; pa_dir = '0; pb_dir = '0;
    irq_flags = '0; irq_enables = '0; edge_rise = 1'b0; pa7_last = 1'b0;
    pit_shift = 4'd10; pit_phase = iopit_pkg::PHASE_COUNTING;
    pit_ticks = iopit_pkg::TICKS_RESET;

    // Directed: flags and timer after reset, rising and falling edges on the top bit of port A, ports, quiet reads
    add_item(iopit_pkg::OP_READ,  5'h05, 8'h00, 8'h00, 1'b0);
    add_item(iopit_pkg::OP_READ,  5'h04, 8'h00, 8'h00, 1'b1);
    add_item(iopit_pkg::OP_WRITE, 5'h01, 8'hff, 8'h00, 1'b0);
    add_item(iopit_pkg::OP_WRITE, 5'h00, 8'h80, 8'h00, 1'b0);
    add_item(iopit_pkg::OP_WRITE, 5'h06, 8'h00, 8'h00, 1'b0);
    add_item(iopit_pkg::OP_WRITE, 5'h00, 8'h00, 8'h00, 1'b0);
    add_item(iopit_pkg::OP_READ,  5'h05, 8'h00, 8'h00, 1'b1);
    add_item(iopit_pkg::OP_READ,  5'h05, 8'h00, 8'h00, 1'b0);
    add_item(iopit_pkg::OP_WRITE, 5'h01, 8'h00, 8'h00, 1'b0);
    add_item(iopit_pkg::OP_WRITE, 5'h07, 8'h00, 8'h00, 1'b0);
    add_item(iopit_pkg::OP_READ,  5'h00, 8'hff, 8'h80, 1'b1);
    add_item(iopit_pkg::OP_READ,  5'h00, 8'hff, 8'h80, 1'b0);
    add_item(iopit_pkg::OP_PINS_A, 5'h00, 8'h00, 8'hff, 1'b0);
    add_item(iopit_pkg::OP_READ,  5'h00, 8'haa, 8'h00, 1'b0);
    add_item(iopit_pkg::OP_PINS_A, 5'h1f, 8'h80, 8'h80, 1'b1);
    add_item(iopit_pkg::OP_PINS_B, 5'h00, 8'h5a, 8'hff, 1'b0);
    add_item(iopit_pkg::OP_WRITE, 5'h03, 8'h0f, 8'h00, 1'b0);
    add_item(iopit_pkg::OP_WRITE, 5'h02, 8'ha5, 8'h00, 1'b0);
    add_item(iopit_pkg::OP_READ,  5'h02, 8'h33, 8'h00, 1'b0);
    add_item(iopit_pkg::OP_READ,  5'h03, 8'h00, 8'h00, 1'b0);
    add_item(iopit_pkg::OP_READ,  5'h01, 8'h00, 8'h00, 1'b0);
    // Timer: expire, read at the last value with the flag kept, then clear it
    add_item(iopit_pkg::OP_WRITE, 5'h1c, 8'h02, 8'h00, 1'b0);
    repeat (4) add_item(iopit_pkg::OP_TICK, 5'h00, 8'h00, 8'h00, 1'b0);
    add_item(iopit_pkg::OP_READ,  5'h1c, 8'h00, 8'h00, 1'b0);
    add_item(iopit_pkg::OP_TICK,  5'h00, 8'h00, 8'h00, 1'b0);
    add_item(iopit_pkg::OP_READ,  5'h04, 8'h00, 8'h00, 1'b0);
    add_item(iopit_pkg::OP_WRITE, 5'h17, 8'hff, 8'h00, 1'b0);
    add_item(iopit_pkg::OP_WRITE, 5'h14, 8'h00, 8'h00, 1'b0);
    add_item(iopit_pkg::OP_TICK,  5'h00, 8'h00, 8'h00, 1'b0);
    add_item(3'd5, 5'h1f, 8'hff, 8'hff, 1'b1);
    add_item(3'd6, 5'h00, 8'h00, 8'h00, 1'b0);
    add_item(3'd7, 5'h15, 8'h55, 8'haa, 1'b0);

    // Random: mostly single items, with timer runs that reach expiry
    while (bus_items.size() < 600) begin
      if ($urandom_range(0, 99) < 25) queue_timer_run();
      else queue_random_item();
    end
    total_items = bus_items.size();

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (results_seen < total_items) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && predicted_outputs.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== io_port_interval_timer_peripheral_core.f =====
+incdir+rtl/core
rtl/core/iopit_pkg.sv
rtl/core/iopit_exec.sv
rtl/core/io_port_interval_timer_peripheral_core.sv
sim/tb.sv
